@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, prop)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/fbs_pkg.sv @@
// Types and constants for the float buffer statistics block.
package fbs_pkg;
  localparam int unsigned IndexBits = 32;
  localparam logic [31:0] CntMax = 32'hFFFF_FFFF;
  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [31:0] PosInfBits = 32'h7F80_0000;
  localparam logic [31:0] NegInfBits = 32'hFF80_0000;
  localparam logic [IndexBits-1:0] PosMax = {IndexBits{1'b1}};

  typedef struct packed {
    logic        valid;
    logic [31:0] bits;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic [31:0] finite_total;
    logic [31:0] nan_total;
    logic [31:0] inf_total;
    logic [31:0] zero_total;
    logic [31:0] min_value;
    logic [31:0] max_value;
    logic [31:0] first_nan_at;
    logic        nan_found;
    logic [31:0] first_inf_at;
    logic        inf_found;
  } summary_t;

  function automatic logic [31:0] order_key(input logic [31:0] b);
    logic [31:0] mag;
    mag = {1'b0, b[30:0]};
    return b[31] ? (32'h8000_0000 - mag) : (32'h8000_0000 + mag);
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == CntMax) ? c : c + 32'd1;
  endfunction
endpackage

@@ sv/float_buffer_statistics.sv @@
// Top level: input register, statistics accumulator and result register.
//   channel | direction | handshake          | fields
//   in      | input     | in_valid/in_stall  | value_bits, last_item
//   out     | output    | out_valid/out_stall| summary fields
// One beat per cycle unless in_stall_o holds the input; each accepted beat is registered in the
// input register, and the summary of a last beat is then registered in the result register.
// Reset clears all counters, extremes and flags; the last beat clears them too.
// The input stalls only when a summary waits and another summary is pending.
`include "assert_macros.svh"
module float_buffer_statistics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_bits_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] finite_total_o,
  output logic [31:0] nan_total_o,
  output logic [31:0] inf_total_o,
  output logic [31:0] zero_total_o,
  output logic [31:0] min_value_o,
  output logic [31:0] max_value_o,
  output logic [31:0] first_nan_at_o,
  output logic        nan_found_o,
  output logic [31:0] first_inf_at_o,
  output logic        inf_found_o
);
  import fbs_pkg::*;

  beat_t       beat_proc;
  logic        beat_valid_q, beat_last_q;
  logic [31:0] beat_bits_q;
  summary_t    sum_c, sum_q;
  logic        done, out_valid_q, hold;

  assign hold       = beat_valid_q && beat_last_q && out_valid_q && out_stall_i;
  assign in_stall_o = hold;
  assign beat_proc  = '{valid: beat_valid_q && !hold, bits: beat_bits_q, last: beat_last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_valid_q <= 1'b0;
    end else if (!hold) begin
      beat_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold && in_valid_i) begin
      beat_bits_q <= value_bits_i;
      beat_last_q <= last_item_i;
    end
  end

  fbs_accum u_accum (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .beat_i(beat_proc),
    .done_o(done),
    .sum_o (sum_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) sum_q <= sum_c;
  end

  assign out_valid_o    = out_valid_q;
  assign finite_total_o = sum_q.finite_total;
  assign nan_total_o    = sum_q.nan_total;
  assign inf_total_o    = sum_q.inf_total;
  assign zero_total_o   = sum_q.zero_total;
  assign min_value_o    = sum_q.min_value;
  assign max_value_o    = sum_q.max_value;
  assign first_nan_at_o = sum_q.first_nan_at;
  assign nan_found_o    = sum_q.nan_found;
  assign first_inf_at_o = sum_q.first_inf_at;
  assign inf_found_o    = sum_q.inf_found;

  `ASSERT_NEXT(a_done_sets_valid, done, out_valid_q)
  `ASSERT_IMPL(a_no_overwrite, (out_valid_q && out_stall_i) |-> !done)
  `ASSERT_NEXT(a_hold_keeps_beat, hold, beat_valid_q && beat_last_q)
endmodule

@@ sv/fbs_accum.sv @@
// Statistics accumulator: classify one registered beat and update state.
module fbs_accum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fbs_pkg::beat_t   beat_i,
  output logic             done_o,
  output fbs_pkg::summary_t sum_o
);
  import fbs_pkg::*;

  logic [IndexBits-1:0] pos_q, pos_d, nan_idx_q, nan_idx_d, inf_idx_q, inf_idx_d;
  logic [31:0] fin_q, fin_d, nan_q, nan_d, inf_q, inf_d, zero_q, zero_d;
  logic [31:0] min_q, min_d, max_q, max_d;
  logic nan_seen_q, nan_seen_d, inf_seen_q, inf_seen_d;
  logic is_nan, is_inf;

  assign is_nan = (beat_i.bits[30:23] == 8'hFF) && (beat_i.bits[22:0] != '0);
  assign is_inf = (beat_i.bits[30:23] == 8'hFF) && (beat_i.bits[22:0] == '0);

  always_comb begin
    pos_d = pos_q; nan_idx_d = nan_idx_q; inf_idx_d = inf_idx_q;
    fin_d = fin_q; nan_d = nan_q; inf_d = inf_q; zero_d = zero_q;
    min_d = min_q; max_d = max_q; nan_seen_d = nan_seen_q; inf_seen_d = inf_seen_q;
    if (is_nan) begin
      nan_d = sat_inc(nan_q);
      if (!nan_seen_q) begin
        nan_seen_d = 1'b1;
        nan_idx_d = pos_q;
      end
    end else if (is_inf) begin
      inf_d = sat_inc(inf_q);
      if (!inf_seen_q) begin
        inf_seen_d = 1'b1;
        inf_idx_d = pos_q;
      end
    end else begin
      if (beat_i.bits[30:0] == '0) zero_d = sat_inc(zero_q);
      if (order_key(beat_i.bits) < order_key(min_q)) min_d = beat_i.bits;
      if (order_key(max_q) < order_key(beat_i.bits)) max_d = beat_i.bits;
      fin_d = sat_inc(fin_q);
    end
    if (pos_q != PosMax) pos_d = pos_q + IndexBits'(1);

    sum_o.finite_total = fin_d;
    sum_o.nan_total    = nan_d;
    sum_o.inf_total    = inf_d;
    sum_o.zero_total   = zero_d;
    sum_o.min_value    = (fin_d == '0) ? QnanBits : min_d;
    sum_o.max_value    = (fin_d == '0) ? QnanBits : max_d;
    sum_o.first_nan_at = nan_seen_d ? 32'(nan_idx_d) : 32'd0;
    sum_o.nan_found    = nan_seen_d;
    sum_o.first_inf_at = inf_seen_d ? 32'(inf_idx_d) : 32'd0;
    sum_o.inf_found    = inf_seen_d;
  end

  assign done_o = beat_i.valid && beat_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; nan_idx_q <= '0; inf_idx_q <= '0;
      fin_q <= '0; nan_q <= '0; inf_q <= '0; zero_q <= '0;
      min_q <= PosInfBits; max_q <= NegInfBits;
      nan_seen_q <= 1'b0; inf_seen_q <= 1'b0;
    end else if (done_o) begin
      pos_q <= '0; nan_idx_q <= '0; inf_idx_q <= '0;
      fin_q <= '0; nan_q <= '0; inf_q <= '0; zero_q <= '0;
      min_q <= PosInfBits; max_q <= NegInfBits;
      nan_seen_q <= 1'b0; inf_seen_q <= 1'b0;
    end else if (beat_i.valid) begin
      pos_q <= pos_d; nan_idx_q <= nan_idx_d; inf_idx_q <= inf_idx_d;
      fin_q <= fin_d; nan_q <= nan_d; inf_q <= inf_d; zero_q <= zero_d;
      min_q <= min_d; max_q <= max_d;
      nan_seen_q <= nan_seen_d; inf_seen_q <= inf_seen_d;
    end
  end
endmodule

@@ tb/tb.sv @@
// Testbench for float_buffer_statistics: random buffers checked against a built-in predictor.
`timescale 1ns / 1ps
module tb;
  import fbs_pkg::*;

  class stats_scoreboard;
    logic [31:0] position, finite_cnt, nan_cnt, inf_cnt, zero_cnt;
    logic [31:0] low_bits, high_bits, nan_idx, inf_idx;
    logic        nan_hit, inf_hit;
    summary_t    summaries[$];
    int          errors, checked;

    function new();
      clear();
      errors = 0;
      checked = 0;
    endfunction

    function void clear();
      position = 0; finite_cnt = 0; nan_cnt = 0; inf_cnt = 0; zero_cnt = 0;
      low_bits = PosInfBits; high_bits = NegInfBits;
      nan_idx = 0; inf_idx = 0; nan_hit = 1'b0; inf_hit = 1'b0;
    endfunction

    function logic [31:0] rank(logic [31:0] b);
      logic [31:0] mag;
      mag = {1'b0, b[30:0]};
      return b[31] ? 32'h8000_0000 - mag : 32'h8000_0000 + mag;
    endfunction

    function logic [31:0] bump(logic [31:0] c);
      return (c == CntMax) ? c : c + 1;
    endfunction

    function void note_beat(logic [31:0] v, logic last);
      summary_t s;
      if (v[30:23] == 8'hFF && v[22:0] != 0) begin
        nan_cnt = bump(nan_cnt);
        if (!nan_hit) begin nan_hit = 1'b1; nan_idx = position; end
      end else if (v[30:23] == 8'hFF) begin
        inf_cnt = bump(inf_cnt);
        if (!inf_hit) begin inf_hit = 1'b1; inf_idx = position; end
      end else begin
        if (v[30:0] == 0) zero_cnt = bump(zero_cnt);
        if (rank(v) < rank(low_bits)) low_bits = v;
        if (rank(high_bits) < rank(v)) high_bits = v;
        finite_cnt = bump(finite_cnt);
      end
      if (position != 32'hFFFF_FFFF) position = position + 1;
      if (!last) return;
      s.finite_total = finite_cnt;
      s.nan_total = nan_cnt;
      s.inf_total = inf_cnt;
      s.zero_total = zero_cnt;
      s.min_value = (finite_cnt == 0) ? QnanBits : low_bits;
      s.max_value = (finite_cnt == 0) ? QnanBits : high_bits;
      s.first_nan_at = nan_hit ? nan_idx : 32'd0;
      s.nan_found = nan_hit;
      s.first_inf_at = inf_hit ? inf_idx : 32'd0;
      s.inf_found = inf_hit;
      summaries.push_back(s);
      clear();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check(summary_t got);
      summary_t e;
      checked++;
      if (summaries.size() == 0) begin
        report("unexpected summary", got.finite_total, 0);
        return;
      end
      e = summaries.pop_front();
      if (got.finite_total !== e.finite_total) report("finite_total", got.finite_total, e.finite_total);
      if (got.nan_total !== e.nan_total) report("nan_total", got.nan_total, e.nan_total);
      if (got.inf_total !== e.inf_total) report("inf_total", got.inf_total, e.inf_total);
      if (got.zero_total !== e.zero_total) report("zero_total", got.zero_total, e.zero_total);
      if (got.min_value !== e.min_value) report("min_value", got.min_value, e.min_value);
      if (got.max_value !== e.max_value) report("max_value", got.max_value, e.max_value);
      if (got.first_nan_at !== e.first_nan_at) report("first_nan_at", got.first_nan_at, e.first_nan_at);
      if (got.nan_found !== e.nan_found) report("nan_found", got.nan_found, e.nan_found);
      if (got.first_inf_at !== e.first_inf_at) report("first_inf_at", got.first_inf_at, e.first_inf_at);
      if (got.inf_found !== e.inf_found) report("inf_found", got.inf_found, e.inf_found);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, last_item_i, out_valid_o, out_stall_i;
  logic [31:0] value_bits_i;
  logic [31:0] finite_total_o, nan_total_o, inf_total_o, zero_total_o;
  logic [31:0] min_value_o, max_value_o, first_nan_at_o, first_inf_at_o;
  logic nan_found_o, inf_found_o;

  stats_scoreboard sb = new();
  int idle_cycles = 0;
  int beats = 0;
  bit calm = 0;

  float_buffer_statistics dut (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    summary_t r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_beat(value_bits_i, last_item_i);
        beats++;
      end
      if (out_valid_o && !out_stall_i) begin
        r.finite_total = finite_total_o; r.nan_total = nan_total_o;
        r.inf_total = inf_total_o; r.zero_total = zero_total_o;
        r.min_value = min_value_o; r.max_value = max_value_o;
        r.first_nan_at = first_nan_at_o; r.nan_found = nan_found_o;
        r.first_inf_at = first_inf_at_o; r.inf_found = inf_found_o;
        sb.check(r);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("watchdog expired");
        $display("float_buffer_statistics verification failed");
        $finish;
      end
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni || calm) out_stall_i <= 0;
    else if (pick_gap() != 0) out_stall_i <= 1;
    else out_stall_i <= 0;
  end

  task send(logic [31:0] v, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    value_bits_i <= v;
    last_item_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: w[30:23] = 8'hFF;
      1: begin w[30:23] = 8'hFF; w[22:0] = '0; end
      2: w[30:0] = '0;
      3: w[30:23] = '0;
      4: w = {w[31], 31'h7F7F_FFFF};
      5: w[30:23] = 8'($urandom_range(120, 135));
      default: ;
    endcase
    return w;
  endfunction

  task send_buffer(int len);
    for (int i = 0; i < len; i++) send(rand_word(), i == len - 1);
  endtask

  initial begin
    logic [31:0] singles[13];
    singles = '{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'hFF80_0001, 32'h7F80_0000,
                32'hFF80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001,
                32'hFFFF_FFFF, 32'h3F80_0000, 32'h807F_FFFF};
    rst_ni = 0;
    in_valid_i = 0;
    value_bits_i = 0;
    last_item_i = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (singles[i]) send(singles[i], 1);
    send(32'h8000_0000, 0); send(32'h0000_0000, 1);
    send(32'h0000_0000, 0); send(32'h8000_0000, 0); send(32'h7F80_0001, 1);
    send(32'hFF80_0000, 0); send(32'h7FFF_FFFF, 0); send(32'h7F80_0000, 0);
    send(32'h7FC0_0001, 1);
    while (beats < 1200) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) send_buffer($urandom_range(30, 80));
      else send_buffer($urandom_range(1, 16));
      if ($urandom_range(0, 19) == 0) begin
        in_valid_i <= 0;
        while (sb.summaries.size() != 0) @(posedge clk_i);
      end
    end
    calm = 0;
    in_valid_i <= 0;
    while (sb.summaries.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    $display("covered %0d beats and %0d summaries: signed zeros, NaN payloads, infinities,",
             beats, sb.checked);
    $display("denormals, finite extremes, empty finite sets, random gaps and stalls");
    if (sb.errors == 0 && sb.summaries.size() == 0)
      $display("float_buffer_statistics verification clean");
    else
      $display("float_buffer_statistics verification failed");
    $finish;
  end
endmodule
